// ----- hw/rtl/ilid_pkg.sv -----
// ---------------------------------------------------------------------------
// ilid_pkg
// Shared types and constants for the indexed list with insert and delete.
// ---------------------------------------------------------------------------
package ilid_pkg;

    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              set;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        logic             rd_en;
        logic [CNT_W-1:0] count;
        status_t          status;
    } ctrl_res_t;

endpackage

// ----- hw/rtl/ilid_cell.sv -----
// ---------------------------------------------------------------------------
// ilid_cell
// One list entry: loads from its lower neighbour on insert, from its upper
// neighbour on delete, or the broadcast word on a write that hits it.
// ---------------------------------------------------------------------------
module ilid_cell
    import ilid_pkg::*;
#(
    parameter int CMP_W = 7,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [DATA_W-1:0] next_data,
    output logic [DATA_W-1:0] data,
    output logic              hit
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CMP_W-1:0]  idx_c;
    logic [CMP_W-1:0]  pos_c;
    logic              above;

    assign idx_c = CMP_W'(INDEX);
    assign pos_c = CMP_W'(cmd.pos);
    assign hit   = (idx_c == pos_c);
    assign above = (idx_c > pos_c);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (above)
                data_next = prev_data;
            else if (hit)
                data_next = cmd.value;
        end
        else if (cmd.del)
        begin
            if (above || hit)
                data_next = next_data;
        end
        else if (cmd.set && hit)
        begin
            data_next = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- hw/rtl/ilid_ctrl.sv -----
// ---------------------------------------------------------------------------
// ilid_ctrl
// Entry count, range and full checks, and the command broadcast to the row.
// ---------------------------------------------------------------------------
module ilid_ctrl
    import ilid_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  op_t               op,
    input  logic [POS_W-1:0]  pos,
    input  logic [DATA_W-1:0] value,
    output cell_cmd_t         cmd,
    output ctrl_res_t         res
);

    localparam int NUM_W = $clog2(LIST_DEPTH + 1);
    localparam int W     = (NUM_W > POS_W) ? NUM_W : POS_W;

    logic [NUM_W-1:0] count_reg;
    logic [NUM_W-1:0] count_next;
    logic [W-1:0]     pos_w;
    logic [W-1:0]     count_w;
    logic [W-1:0]     count_after;
    logic             full;
    status_t          status;
    logic             ok;

    assign pos_w   = W'(pos);
    assign count_w = W'(count_reg);
    assign full    = (count_w == W'(LIST_DEPTH));

    always_comb
    begin
        status = ST_OK;
        unique case (op)
            OP_INSERT:
            begin
                if (pos_w > count_w)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
            end
            OP_DELETE, OP_GET, OP_SET:
            begin
                if (pos_w >= count_w)
                    status = ST_RANGE;
            end
            default: status = ST_RANGE;
        endcase
    end

    assign ok        = (status == ST_OK);
    assign cmd.ins   = fire && ok && (op == OP_INSERT);
    assign cmd.del   = fire && ok && (op == OP_DELETE);
    assign cmd.set   = fire && ok && (op == OP_SET);
    assign cmd.pos   = pos;
    assign cmd.value = value;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + NUM_W'(1);
        else if (cmd.del)
            count_next = count_reg - NUM_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign count_after = W'(count_next);
    assign res.rd_en   = ok && (op == OP_GET);
    assign res.count   = count_after[CNT_W-1:0];
    assign res.status  = status;

endmodule

// ----- hw/rtl/indexed_list_insert_delete.sv -----
// ---------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of 32-bit words held in a row of cells; insert, delete, get
// and set at a position, one result word per input word.
// Each accepted word's result is in the output register from the next cycle on.
// One word per cycle while the result side does not stall; the whole row shifts in the accepting cycle.
// Reset clears the entry count and the output valid; cell contents are
// undefined until written.
// ---------------------------------------------------------------------------
module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // operation[1:0], position[8:2], value[40:9]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // read_value[31:0], list_count[38:32], status[40:39]
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic              fire;
    op_t               op;
    cell_cmd_t         cmd;
    ctrl_res_t         res;
    logic [DATA_W-1:0] cell_data [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_hit;
    logic [DATA_W-1:0] rd_word;

    logic              out_valid_reg;
    logic [DATA_W-1:0] rd_value_reg;
    logic [CNT_W-1:0]  count_out_reg;
    status_t           status_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tdata[1:0]);

    ilid_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .op    (op),
        .pos   (s_axis_tdata[8:2]),
        .value (s_axis_tdata[40:9]),
        .cmd   (cmd),
        .res   (res)
    );

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_w;
        logic [DATA_W-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_mid_lo
            assign prev_w = cell_data[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_mid_hi
            assign next_w = cell_data[i+1];
        end

        ilid_cell #(
            .CMP_W (CMP_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .prev_data (prev_w),
            .next_data (next_w),
            .data      (cell_data[i]),
            .hit       (cell_hit[i])
        );
    end

    // one-hot select of the addressed cell
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (cell_hit[i])
                rd_word = rd_word | cell_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_value_reg  <= res.rd_en ? rd_word : '0;
            count_out_reg <= res.count;
            status_reg    <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, status_reg, count_out_reg, rd_value_reg};

    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tvalid)
        else $error("accepted word did not produce a result");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (status_reg == ST_FULL)) |-> (count_out_reg == CNT_W'(LIST_DEPTH)))
        else $error("full status with count below depth");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (status_reg != ST_OK)) |-> (rd_value_reg == '0))
        else $error("read word not zero on failed operation");

endmodule

// ----- tb/indexed_list_insert_delete_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_list_insert_delete_checker
// Watches both stream channels of the indexed list. Each accepted command
// word is applied to a shadow list, and the expected result is queued.
// Each accepted result word is compared field by field with the oldest
// expected result.
// ---------------------------------------------------------------------------
module indexed_list_insert_delete_checker
    import ilid_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    output int          errors,
    output int          pending,
    output int          list_len
);

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  list_count;
        status_t           status;
    } outcome_t;

    logic [DATA_W-1:0] shadow_cells [LIST_DEPTH];
    int                shadow_len;
    outcome_t          due_results [$];
    int                results_seen;

    task automatic log_mismatch(input string msg);
        $display("checker: result %0d: %s", results_seen, msg);
        errors++;
    endtask

    function automatic outcome_t apply_command(input op_t op, input logic [POS_W-1:0] pos,
                                               input logic [DATA_W-1:0] val);
        outcome_t res;
        int       p;
        p = int'(pos);
        res.read_value = '0;
        res.status     = ST_OK;
        if (op == OP_INSERT)
        begin
            if (p > shadow_len)
                res.status = ST_RANGE;
            else if (shadow_len >= LIST_DEPTH)
                res.status = ST_FULL;
            else
            begin
                for (int i = shadow_len; i > p; i--)
                    shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[p] = val;
                shadow_len++;
            end
        end
        else if (p >= shadow_len)
            res.status = ST_RANGE;
        else if (op == OP_DELETE)
        begin
            for (int i = p; i + 1 < shadow_len; i++)
                shadow_cells[i] = shadow_cells[i+1];
            shadow_len--;
        end
        else if (op == OP_GET)
            res.read_value = shadow_cells[p];
        else
            shadow_cells[p] = val;
        res.list_count = CNT_W'(shadow_len);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            errors       = 0;
            shadow_len   = 0;
            results_seen = 0;
            due_results.delete();
            pending  <= 0;
            list_len <= 0;
        end
        else
        begin
            // results first: a word accepted now never answers a command accepted now
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                    log_mismatch("result word with nothing outstanding");
                else
                begin
                    want = due_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.read_value)
                        log_mismatch($sformatf("read_value %h, expected %h",
                                               m_axis_tdata[31:0], want.read_value));
                    if (m_axis_tdata[38:32] !== want.list_count)
                        log_mismatch($sformatf("list_count %0d, expected %0d",
                                               m_axis_tdata[38:32], want.list_count));
                    if (m_axis_tdata[40:39] !== want.status)
                        log_mismatch($sformatf("status %0d, expected %0d",
                                               m_axis_tdata[40:39], want.status));
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(apply_command(op_t'(s_axis_tdata[1:0]),
                                                    s_axis_tdata[8:2], s_axis_tdata[40:9]));
            pending  <= due_results.size();
            list_len <= shadow_len;
        end
    end

endmodule

// ----- tb/tb_indexed_list_insert_delete.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_indexed_list_insert_delete
// Drives insert, delete, get and set words into the indexed list: a short
// directed run over the edge cases, then random words in fill, drain and
// mixed phases so the list runs empty and full repeatedly. Both sides idle
// in random bursts; the checker beside the block scores every result word.
// ---------------------------------------------------------------------------
module tb_indexed_list_insert_delete;
    import ilid_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int RANDOM_CMDS = 1925;
    localparam int CALM_TAIL   = 200;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    int errors;
    int pending;
    int list_len;
    int src_pct  = 0;
    int sink_pct = 0;
    bit calm     = 1'b0;

    indexed_list_insert_delete #(
        .LIST_DEPTH (LIST_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indexed_list_insert_delete_checker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .list_len      (list_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    task automatic send_word(input op_t op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        int gap;
        if (!calm && $urandom_range(0, 99) < src_pct)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, val, pos, op};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else if (!calm && $urandom_range(0, 99) < sink_pct)
            begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(0, 3);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int                phase;
        int                pick;
        int                len;
        op_t               op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int                w_ins;
        int                w_del;
        int                w_get;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, extremes of value, boundaries of position
        send_word(OP_GET,    7'd0,   32'h0000_0000);
        send_word(OP_DELETE, 7'd0,   32'hFFFF_FFFF);
        send_word(OP_SET,    7'd0,   32'h1234_5678);
        send_word(OP_INSERT, 7'd1,   32'h0000_0001);
        send_word(OP_INSERT, 7'd127, 32'h0BAD_0BAD);
        send_word(OP_INSERT, 7'd0,   32'h8000_0000);
        send_word(OP_INSERT, 7'd1,   32'h7FFF_FFFF);
        send_word(OP_INSERT, 7'd0,   32'hFFFF_FFFF);
        send_word(OP_INSERT, 7'd2,   32'h0000_0000);
        send_word(OP_GET,    7'd0,   32'hFFFF_FFFF);
        send_word(OP_GET,    7'd1,   32'h0000_0000);
        send_word(OP_GET,    7'd2,   32'hFFFF_FFFF);
        send_word(OP_GET,    7'd3,   32'h0000_0000);
        send_word(OP_GET,    7'd4,   32'h0000_0000);
        send_word(OP_SET,    7'd3,   32'h5555_5555);
        send_word(OP_GET,    7'd3,   32'h0000_0000);
        send_word(OP_SET,    7'd4,   32'hAAAA_AAAA);
        send_word(OP_DELETE, 7'd4,   32'h0000_0000);
        send_word(OP_DELETE, 7'd1,   32'h0000_0000);
        send_word(OP_DELETE, 7'd2,   32'h0000_0000);
        send_word(OP_GET,    7'd1,   32'h0000_0000);
        send_word(OP_DELETE, 7'd0,   32'h0000_0000);
        send_word(OP_INSERT, 7'd127, 32'hAAAA_AAAA);
        send_word(OP_DELETE, 7'd0,   32'h0000_0000);

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 150 == 0)
            begin
                phase    = (n / 150) % 4;
                pick     = $urandom_range(0, 2);
                src_pct  = (pick == 0) ? 0 : (pick == 1) ? 15 : 35;
                pick     = $urandom_range(0, 2);
                sink_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 35;
            end
            calm = (n >= RANDOM_CMDS - CALM_TAIL);
            // fill, mixed, drain, mixed
            w_ins = (phase == 0) ? 60 : (phase == 2) ? 10 : 30;
            w_del = (phase == 0) ? 10 : (phase == 2) ? 60 : 25;
            w_get = 15;
            len   = list_len;

            pick = $urandom_range(0, 99);
            if (pick < w_ins)
                op = OP_INSERT;
            else if (pick < w_ins + w_del)
                op = OP_DELETE;
            else if (pick < w_ins + w_del + w_get)
                op = OP_GET;
            else
                op = OP_SET;

            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                op  = op_t'($urandom_range(0, 3));
                pos = POS_W'($urandom_range(0, 127));
            end
            else if (pick < 88)
            begin
                if (op == OP_INSERT)
                    pos = POS_W'($urandom_range(0, len));
                else if (len > 0)
                    pos = POS_W'($urandom_range(0, len - 1));
                else
                    pos = '0;
            end
            else if (pick < 94)
                pos = POS_W'((op == OP_INSERT) ? len + 1 : len);
            else
                pos = POS_W'($urandom_range(0, 127));

            pick = $urandom_range(0, 99);
            if (pick < 3)
                val = 32'h8000_0000;
            else if (pick < 6)
                val = 32'h7FFF_FFFF;
            else if (pick < 8)
                val = 32'hFFFF_FFFF;
            else if (pick < 10)
                val = 32'h0000_0000;
            else
                val = $urandom;

            send_word(op, pos, val);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
